/* rtl/core/smsc_pkg.sv */
// Shared types, fixed-point constants and the multiply schedule for the master clip stage.
`timescale 1ns / 1ps

package smsc_pkg;

  // Sample and phase widths
  localparam int SAMPLE_BITS = 24;
  localparam int PHASE_BITS  = 32;

  // Stream payload
  localparam int LAYER_W = 24;
  localparam int VOL_W   = 16;
  localparam int IN_W    = 4 * LAYER_W + VOL_W;
  localparam int OUT_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;
  localparam int STEP_CFG_W = 32;
  localparam int MODE_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TONE_GAIN  = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_MIX_MODE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MIX_CLIP = 2'd0,
    MIX_TONE = 2'd1,
    MIX_SUM  = 2'd2
  } mix_mode_t;

  // Datapath widths
  localparam int OPD_W   = 33;             // multiplier operand, signed
  localparam int PROD_W  = 2 * OPD_W;      // multiplier product, signed
  localparam int SUM_W   = LAYER_W + 1;    // layer sum
  localparam int VOLG_W  = 30;             // volume times clip gain
  localparam int Y_W     = 31;             // folded argument, scale 2^30
  localparam int SQ_W    = 29;             // argument squared, scale 2^30
  localparam int VAL_W   = 34;             // polynomial or scaled tone
  localparam int MIX_W   = 35;             // clip plus tone
  localparam int CLAMP_W = 51;             // clamped clip product

  // Fixed-point shifts
  localparam int FRAC_Q     = 30;
  localparam int GAIN_FRAC  = 15;
  localparam int CLIP_SHIFT = 21;
  localparam int C3_SPLIT   = 32;
  localparam int OUT_SHIFT  = 33 - SAMPLE_BITS;

  // Product with the fraction bits dropped
  localparam int HI_W = PROD_W - FRAC_Q;

  // Coefficients; C3 is carried as C3 - 2^32 so that it fits the operand width
  localparam logic signed [OPD_W-1:0] CLIP_GAIN = 33'sd10407;
  localparam logic signed [OPD_W-1:0] POLY_C1   = 33'sd3373256577;
  localparam logic signed [OPD_W-1:0] POLY_C3M  = 33'sd1216270314;
  localparam logic signed [OPD_W-1:0] POLY_C5   = 33'sd2432540627;

  localparam logic signed [PROD_W-1:0]  CLAMP_HI   = 66'sd562949953421312;
  localparam logic signed [PROD_W-1:0]  CLAMP_LO   = -CLAMP_HI;
  localparam logic signed [CLAMP_W-1:0] ROUND_CLIP = 51'sd1048576;
  localparam logic        [Y_W-1:0]     HALF_Q30   = 31'd536870912;

  localparam logic signed [MIX_W-1:0] ROUND_OUT = MIX_W'(64'sd1 <<< (OUT_SHIFT - 1));
  localparam logic signed [MIX_W-1:0] OUT_MAX   = MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MIX_W-1:0] OUT_MIN   = -OUT_MAX - 1;

  // Multiplier operations and channels
  typedef enum logic [2:0] {
    OP_VOLG,
    OP_CLIP,
    OP_SQ,
    OP_A,
    OP_B,
    OP_Y,
    OP_GAIN
  } op_t;

  typedef enum logic [1:0] {
    CH_LEFT  = 2'd0,
    CH_RIGHT = 2'd1,
    CH_TONE  = 2'd2
  } ch_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    op_t  op;
    ch_t  ch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  typedef struct packed {
    op_t op;
    ch_t ch;
  } sched_t;

  localparam int MUL_STEPS = 16;
  localparam int STEP_W    = $clog2(MUL_STEPS);

  // Three chains interleaved so each result is written back before its next use
  localparam sched_t SCHED [MUL_STEPS] = '{
    '{OP_VOLG, CH_LEFT},
    '{OP_SQ,   CH_TONE},
    '{OP_CLIP, CH_LEFT},
    '{OP_CLIP, CH_RIGHT},
    '{OP_A,    CH_TONE},
    '{OP_SQ,   CH_LEFT},
    '{OP_SQ,   CH_RIGHT},
    '{OP_B,    CH_TONE},
    '{OP_A,    CH_LEFT},
    '{OP_A,    CH_RIGHT},
    '{OP_Y,    CH_TONE},
    '{OP_B,    CH_LEFT},
    '{OP_B,    CH_RIGHT},
    '{OP_GAIN, CH_TONE},
    '{OP_Y,    CH_LEFT},
    '{OP_Y,    CH_RIGHT}
  };

endpackage

/* rtl/core/stereo_master_soft_clip_tone_mix_core.sv */
// Top level of the stereo master soft clipper with test tone mix.
// An input transfer runs the multiply schedule, a write-back drain and the output load, then
// out_tvalid rises; the load waits while the output register is full. The next stereo sample
// is accepted only after 16 products on one shared 33x33 multiplier and that load are done.
// The output register holds a finished sample while the next one is computed.
// Reset (rst_n low, synchronous) clears the controller, output valid, mode, gain,
// phase step and tone phase.
`timescale 1ns / 1ps

module stereo_master_soft_clip_tone_mix_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // left_layer_a, right_layer_a, left_layer_b, right_layer_b, main_vol
  input  logic [smsc_pkg::IN_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_left, out_right
  output logic [smsc_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  smsc_pkg::cmd_t cmd;
  smsc_pkg::sts_t sts;

  smsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/core/smsc_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module smsc_mul (
  input  logic                                clk,
  input  logic signed [smsc_pkg::OPD_W-1:0]   a,
  input  logic signed [smsc_pkg::OPD_W-1:0]   b,
  output logic signed [smsc_pkg::PROD_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

/* rtl/core/smsc_dp.sv */
// Datapath: config registers, tone phase, operand select, write-back and output stage.
`timescale 1ns / 1ps

module smsc_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smsc_pkg::cmd_t                     cmd,
  output smsc_pkg::sts_t                     sts,
  input  logic [smsc_pkg::IN_W-1:0]          in_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [smsc_pkg::OUT_W-1:0]         out_tdata
);

  // Config and tone state
  logic [smsc_pkg::GAIN_W-1:0]     gain_r;
  logic [smsc_pkg::STEP_CFG_W-1:0] step_r;
  logic [smsc_pkg::MODE_W-1:0]     mode_r;
  logic [smsc_pkg::PHASE_BITS-1:0] phase_r;

  // Per-item working registers
  logic signed [smsc_pkg::SUM_W-1:0] sum_r [2];
  logic [smsc_pkg::VOL_W-1:0]        vol_r;
  logic [smsc_pkg::VOLG_W-1:0]       volg_r;
  logic signed [smsc_pkg::Y_W-1:0]   y_r   [3];
  logic [smsc_pkg::SQ_W-1:0]         sq_r  [3];
  logic signed [smsc_pkg::OPD_W-1:0] am_r  [3];
  logic signed [smsc_pkg::OPD_W-1:0] bv_r  [3];
  logic signed [smsc_pkg::VAL_W-1:0] val_r [3];

  logic                 wb_vld_r;
  smsc_pkg::op_t        wb_op_r;
  smsc_pkg::ch_t        wb_ch_r;

  logic signed [smsc_pkg::OPD_W-1:0]  mul_a;
  logic signed [smsc_pkg::OPD_W-1:0]  mul_b;
  logic signed [smsc_pkg::PROD_W-1:0] p_r;

  logic signed [smsc_pkg::LAYER_W-1:0] la, ra, lb, rb;
  logic [smsc_pkg::PHASE_BITS-1:0]     ph_u;
  logic [smsc_pkg::PHASE_BITS-1:0]     ph_mag;
  logic [smsc_pkg::PHASE_BITS+30:0]    ph_ext;
  logic signed [smsc_pkg::Y_W-1:0]     tone_y;

  logic signed [smsc_pkg::CLAMP_W-1:0] clip_t;
  logic signed [smsc_pkg::CLAMP_W-1:0] clip_rnd;
  logic signed [smsc_pkg::Y_W-1:0]     clip_y;
  logic signed [smsc_pkg::OPD_W-1:0]   am_nxt;
  logic signed [smsc_pkg::HI_W-1:0]    p_hi;
  logic signed [smsc_pkg::HI_W-1:0]    bv_full;

  logic                                out_valid_r;
  logic [smsc_pkg::SAMPLE_BITS-1:0]    out_left_r;
  logic [smsc_pkg::SAMPLE_BITS-1:0]    out_right_r;

  function automatic logic [smsc_pkg::SAMPLE_BITS-1:0] to_out(
    input logic signed [smsc_pkg::VAL_W-1:0]  clip,
    input logic signed [smsc_pkg::VAL_W-1:0]  tone,
    input logic        [smsc_pkg::MODE_W-1:0] mode
  );
    logic signed [smsc_pkg::MIX_W-1:0] mixed;
    logic signed [smsc_pkg::MIX_W-1:0] rnd;
    logic signed [smsc_pkg::MIX_W-1:0] shr;
    case (mode)
      smsc_pkg::MIX_CLIP: mixed = smsc_pkg::MIX_W'(clip);
      smsc_pkg::MIX_TONE: mixed = smsc_pkg::MIX_W'(tone);
      smsc_pkg::MIX_SUM:  mixed = smsc_pkg::MIX_W'(clip) + smsc_pkg::MIX_W'(tone);
      default:            mixed = smsc_pkg::MIX_W'(clip) + smsc_pkg::MIX_W'(tone);
    endcase
    rnd = mixed + smsc_pkg::ROUND_OUT;
    shr = rnd >>> smsc_pkg::OUT_SHIFT;
    if (shr > smsc_pkg::OUT_MAX) begin
      to_out = smsc_pkg::SAMPLE_BITS'(smsc_pkg::OUT_MAX);
    end else if (shr < smsc_pkg::OUT_MIN) begin
      to_out = smsc_pkg::SAMPLE_BITS'(smsc_pkg::OUT_MIN);
    end else begin
      to_out = smsc_pkg::SAMPLE_BITS'(shr);
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      step_r <= '0;
      mode_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        smsc_pkg::CFG_TONE_GAIN:  gain_r <= cfg_data[smsc_pkg::GAIN_W-1:0];
        smsc_pkg::CFG_PHASE_STEP: step_r <= cfg_data[smsc_pkg::STEP_CFG_W-1:0];
        smsc_pkg::CFG_MIX_MODE:   mode_r <= cfg_data[smsc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the tone when a result is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.out_load) begin
      phase_r <= phase_r + step_r[smsc_pkg::STEP_CFG_W-1 -: smsc_pkg::PHASE_BITS];
    end
  end

  assign la = in_tdata[smsc_pkg::LAYER_W-1:0];
  assign ra = in_tdata[2*smsc_pkg::LAYER_W-1:smsc_pkg::LAYER_W];
  assign lb = in_tdata[3*smsc_pkg::LAYER_W-1:2*smsc_pkg::LAYER_W];
  assign rb = in_tdata[4*smsc_pkg::LAYER_W-1:3*smsc_pkg::LAYER_W];

  // Fold the phase, shifted by a quarter cycle, into the polynomial's argument range
  always_comb begin
    ph_u   = {~phase_r[smsc_pkg::PHASE_BITS-1], phase_r[smsc_pkg::PHASE_BITS-2:0]};
    ph_mag = ph_u[smsc_pkg::PHASE_BITS-1] ? (~ph_u + 1'b1) : ph_u;
    ph_ext = {ph_mag, 31'b0} >> smsc_pkg::PHASE_BITS;
    tone_y = $signed(smsc_pkg::HALF_Q30 - ph_ext[smsc_pkg::Y_W-1:0]);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      smsc_pkg::OP_VOLG: begin
        mul_a = smsc_pkg::OPD_W'(vol_r);
        mul_b = smsc_pkg::CLIP_GAIN;
      end
      smsc_pkg::OP_CLIP: begin
        mul_a = smsc_pkg::OPD_W'(sum_r[cmd.ch[0]]);
        mul_b = smsc_pkg::OPD_W'(volg_r);
      end
      smsc_pkg::OP_SQ: begin
        mul_a = smsc_pkg::OPD_W'(y_r[cmd.ch]);
        mul_b = smsc_pkg::OPD_W'(y_r[cmd.ch]);
      end
      smsc_pkg::OP_A: begin
        mul_a = smsc_pkg::POLY_C5;
        mul_b = smsc_pkg::OPD_W'(sq_r[cmd.ch]);
      end
      smsc_pkg::OP_B: begin
        mul_a = am_r[cmd.ch];
        mul_b = smsc_pkg::OPD_W'(sq_r[cmd.ch]);
      end
      smsc_pkg::OP_Y: begin
        mul_a = smsc_pkg::OPD_W'(y_r[cmd.ch]);
        mul_b = bv_r[cmd.ch];
      end
      smsc_pkg::OP_GAIN: begin
        mul_a = smsc_pkg::OPD_W'(val_r[cmd.ch]);
        mul_b = smsc_pkg::OPD_W'(gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  smsc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_op_r <= cmd.op;
    wb_ch_r <= cmd.ch;
  end

  // Write-back arithmetic on the registered product
  always_comb begin
    if (p_r > smsc_pkg::CLAMP_HI) begin
      clip_t = smsc_pkg::CLAMP_W'(smsc_pkg::CLAMP_HI);
    end else if (p_r < smsc_pkg::CLAMP_LO) begin
      clip_t = smsc_pkg::CLAMP_W'(smsc_pkg::CLAMP_LO);
    end else begin
      clip_t = smsc_pkg::CLAMP_W'(p_r);
    end
    clip_rnd = clip_t + smsc_pkg::ROUND_CLIP;
    // within the clamp range the fold reduces to a doubling
    clip_y   = {clip_rnd[smsc_pkg::CLAMP_W-1:smsc_pkg::CLIP_SHIFT], 1'b0};

    am_nxt  = $signed(p_r[smsc_pkg::FRAC_Q+smsc_pkg::OPD_W-1:smsc_pkg::FRAC_Q])
              - smsc_pkg::POLY_C3M;
    p_hi    = p_r[smsc_pkg::PROD_W-1:smsc_pkg::FRAC_Q];
    // restore the 2^32 part of C3 that the operand left out
    bv_full = p_hi
              - $signed(smsc_pkg::HI_W'({sq_r[wb_ch_r],
                                         (smsc_pkg::C3_SPLIT - smsc_pkg::FRAC_Q)'(0)}))
              + smsc_pkg::HI_W'(smsc_pkg::POLY_C1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r[0]              <= smsc_pkg::SUM_W'(la) + smsc_pkg::SUM_W'(lb);
      sum_r[1]              <= smsc_pkg::SUM_W'(ra) + smsc_pkg::SUM_W'(rb);
      vol_r                 <= in_tdata[smsc_pkg::IN_W-1 -: smsc_pkg::VOL_W];
      y_r[smsc_pkg::CH_TONE] <= tone_y;
    end else if (wb_vld_r) begin
      case (wb_op_r)
        smsc_pkg::OP_VOLG: volg_r           <= p_r[smsc_pkg::VOLG_W-1:0];
        smsc_pkg::OP_CLIP: y_r[wb_ch_r]     <= clip_y;
        smsc_pkg::OP_SQ:   sq_r[wb_ch_r]    <=
                             p_r[smsc_pkg::FRAC_Q+smsc_pkg::SQ_W-1:smsc_pkg::FRAC_Q];
        smsc_pkg::OP_A:    am_r[wb_ch_r]    <= am_nxt;
        smsc_pkg::OP_B:    bv_r[wb_ch_r]    <= smsc_pkg::OPD_W'(bv_full);
        smsc_pkg::OP_Y:    val_r[wb_ch_r]   <=
                             p_r[smsc_pkg::FRAC_Q+smsc_pkg::VAL_W-1:smsc_pkg::FRAC_Q];
        smsc_pkg::OP_GAIN: val_r[wb_ch_r]   <=
                             p_r[smsc_pkg::GAIN_FRAC+smsc_pkg::VAL_W-1:smsc_pkg::GAIN_FRAC];
        default: ;
      endcase
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_r  <= to_out(val_r[smsc_pkg::CH_LEFT],  val_r[smsc_pkg::CH_TONE], mode_r);
      out_right_r <= to_out(val_r[smsc_pkg::CH_RIGHT], val_r[smsc_pkg::CH_TONE], mode_r);
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = smsc_pkg::OUT_W'({out_right_r, out_left_r});

endmodule

/* rtl/core/smsc_ctrl.sv */
// Controller: accepts an item, steps the multiply schedule and hands off the result.
`timescale 1ns / 1ps

module smsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  smsc_pkg::sts_t  sts,
  output smsc_pkg::cmd_t  cmd
);

  smsc_pkg::st_t                 state_r, state_nxt;
  logic [smsc_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smsc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.op       = smsc_pkg::OP_VOLG;
    cmd.ch       = smsc_pkg::CH_LEFT;
    cmd.out_load = 1'b0;
    case (state_r)
      smsc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = smsc_pkg::ST_RUN;
        end
      end
      smsc_pkg::ST_RUN: begin
        cmd.mul_en = 1'b1;
        cmd.op     = smsc_pkg::SCHED[cnt_r].op;
        cmd.ch     = smsc_pkg::SCHED[cnt_r].ch;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == smsc_pkg::STEP_W'(smsc_pkg::MUL_STEPS - 1)) begin
          state_nxt = smsc_pkg::ST_DRAIN;
        end
      end
      smsc_pkg::ST_DRAIN: begin
        // last product writes back here
        state_nxt = smsc_pkg::ST_OUT;
      end
      smsc_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = smsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
